// File: sv/oli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oli_pkg
// Shared types and constants for the ordered list block and its cells.
// ----------------------------------------------------------------------------
package oli_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int OLEN_W   = 7;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_END   = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_END   = 3'd4,
    REQ_DEL_POS   = 3'd5,
    REQ_DISPLAY   = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BOUNDS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_DISP = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [IDX_W-1:0]          pos;
    logic [IDX_W-1:0]          last_idx;
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  head;
  } cell_cmd_t;

endpackage

// File: sv/oli_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oli_cell
// One list entry: holds, shifts in from either neighbor, loads a new value,
// or takes part in a rotation of the occupied entries.
// ----------------------------------------------------------------------------
module oli_cell
  import oli_pkg::*;
(
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic [IDX_W-1:0]         cell_idx,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      CELL_INS: begin
        if (cell_idx > cmd.pos) begin
          data_nxt = left_data;
        end else if (cell_idx == cmd.pos) begin
          data_nxt = cmd.value;
        end
      end
      CELL_DEL: begin
        if (cell_idx >= cmd.pos) begin
          data_nxt = right_data;
        end
      end
      CELL_ROT: begin
        if (cell_idx < cmd.last_idx) begin
          data_nxt = right_data;
        end else if (cell_idx == cmd.last_idx) begin
          data_nxt = cmd.head;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// File: sv/ordered_list_insert_delete_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_top
// Ordered list of signed 32-bit values held in a chain of CAPACITY cells.
// ----------------------------------------------------------------------------
// Every insert or delete that is taken shifts all cells toward or away from
// the target position at once, and the single result beat goes to the output
// register in the same edge. Displaying an empty list gives one empty-status
// beat; else the occupied cells rotate by one each cycle while the output
// register is free or being drained, cell zero feeding the output register,
// so after the last element the list is back in order. A new command is taken
// only while no display is running and the output register is free or being
// drained. Results stall cleanly under out_stall.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_top
  import oli_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_req_type,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_element_value,
  output logic [POS_W-1:0]         out_element_index,
  output logic [OLEN_W-1:0]        out_length_out,
  output logic                     out_last
);

  state_t                   state_r, state_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [IDX_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  status_r, status_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic [IDX_W-1:0]         index_r, index_nxt;
  logic [OLEN_W-1:0]        olen_r, olen_nxt;
  logic                     last_r, last_nxt;

  logic                     slot_free;
  logic                     accept;
  logic                     load_out;
  logic [OLEN_W-1:0]        len7;
  logic [OLEN_W-1:0]        ins_pos;
  logic [OLEN_W-1:0]        del_pos;
  logic                     disp_last;
  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && slot_free);
  assign accept    = in_valid && !in_stall;
  assign len7      = OLEN_W'(len_r);
  assign disp_last = (LEN_W'(cnt_r) == LEN_W'(len_r - 1'b1));

  always_comb begin
    ins_pos = {1'b0, in_position};
    del_pos = {1'b0, in_position};
    case (req_t'(in_req_type))
      REQ_INS_FRONT: ins_pos = '0;
      REQ_INS_END:   ins_pos = len7;
      REQ_DEL_FRONT: del_pos = '0;
      REQ_DEL_END:   del_pos = OLEN_W'(len7 - 1'b1);
      default: begin
        ins_pos = {1'b0, in_position};
        del_pos = {1'b0, in_position};
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    load_out     = 1'b0;
    status_nxt   = ST_OK;
    value_nxt    = '0;
    index_nxt    = '0;
    last_nxt     = 1'b1;
    cmd.op       = CELL_HOLD;
    cmd.pos      = '0;
    cmd.last_idx = IDX_W'(len_r - 1'b1);
    cmd.value    = in_value_in;
    cmd.head     = cell_data[0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (req_t'(in_req_type))
            REQ_INS_FRONT, REQ_INS_END, REQ_INS_POS: begin
              load_out = 1'b1;
              if (ins_pos > len7) begin
                status_nxt = ST_BOUNDS;
              end else if (len7 == OLEN_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                cmd.op  = CELL_INS;
                cmd.pos = IDX_W'(ins_pos);
                len_nxt = LEN_W'(len_r + 1'b1);
              end
            end
            REQ_DEL_FRONT, REQ_DEL_END, REQ_DEL_POS: begin
              load_out = 1'b1;
              if (len_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (del_pos >= len7) begin
                status_nxt = ST_BOUNDS;
              end else begin
                cmd.op  = CELL_DEL;
                cmd.pos = IDX_W'(del_pos);
                len_nxt = LEN_W'(len_r - 1'b1);
              end
            end
            REQ_DISPLAY: begin
              if (len_r == '0) begin
                load_out   = 1'b1;
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_DISP;
                cnt_nxt   = '0;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_DISP: begin
        if (slot_free) begin
          load_out  = 1'b1;
          value_nxt = cell_data[0];
          index_nxt = cnt_r;
          last_nxt  = disp_last;
          cmd.op    = CELL_ROT;
          cnt_nxt   = IDX_W'(cnt_r + 1'b1);
          if (disp_last) begin
            state_nxt = S_IDLE;
            cnt_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    olen_nxt = OLEN_W'(len_nxt);
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (slot_free) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      index_r  <= index_nxt;
      olen_r   <= olen_nxt;
      last_r   <= last_nxt;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = in_value_in;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_final
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    oli_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cell_idx   (IDX_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i])
    );
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_element_value = value_r;
  assign out_element_index = POS_W'(index_r);
  assign out_length_out    = olen_r;
  assign out_last          = last_r;

endmodule

// File: sv/oli_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oli_checker
// Port-level checks on result beats of the ordered list block.
// ----------------------------------------------------------------------------
module oli_checker
  import oli_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [1:0]               out_status,
  input logic signed [DATA_W-1:0] out_element_value,
  input logic [POS_W-1:0]         out_element_index,
  input logic [OLEN_W-1:0]        out_length_out,
  input logic                     out_last
);

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_length_out <= OLEN_W'(CAPACITY))
    else $error("length beyond capacity");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_last && out_element_value == '0 && out_element_index == '0))
    else $error("error beat not a lone final beat with zero payload");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_length_out == OLEN_W'(CAPACITY))
    else $error("full reported below capacity");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_status) && $stable(out_element_value) &&
       $stable(out_element_index) && $stable(out_length_out) && $stable(out_last)))
    else $error("stalled beat changed");

endmodule

bind ordered_list_insert_delete_top oli_checker u_oli_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_element_value (out_element_value),
  .out_element_index (out_element_index),
  .out_length_out    (out_length_out),
  .out_last          (out_last)
);

// File: tb/list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_checker
// Shadow list and result scoreboard for the ordered list block.
// ----------------------------------------------------------------------------
// Watches both channels. Every command beat taken by the block is applied to
// a shadow copy of the list, which yields the result beats the block owes:
// one status beat per insert, delete or unused code, one beat per element for
// a display (one empty-status beat if empty). Every result beat taken from the
// block is compared field by field with the oldest beat still owed.
// ----------------------------------------------------------------------------
module list_checker
  import oli_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [2:0]               in_req_type,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value_in,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [1:0]               out_status,
  input  logic signed [DATA_W-1:0] out_element_value,
  input  logic [POS_W-1:0]         out_element_index,
  input  logic [OLEN_W-1:0]        out_length_out,
  input  logic                     out_last,
  output int                       fail_count,
  output int                       pending,
  output int                       list_len,
  output int                       beats_checked
);

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         index;
    logic [OLEN_W-1:0]        length;
    logic                     last;
  } list_beat_t;

  logic signed [DATA_W-1:0] shadow_list[$];
  list_beat_t               owed_beats[$];
  int                       errors;
  int                       checked;

  function automatic status_t insert_value(int unsigned pos, logic signed [DATA_W-1:0] v);
    if (pos > shadow_list.size()) return ST_BOUNDS;
    if (shadow_list.size() >= CAPACITY) return ST_FULL;
    shadow_list.insert(pos, v);
    return ST_OK;
  endfunction

  function automatic status_t delete_value(int unsigned pos);
    if (shadow_list.size() == 0) return ST_EMPTY;
    if (pos >= shadow_list.size()) return ST_BOUNDS;
    shadow_list.delete(pos);
    return ST_OK;
  endfunction

  function automatic void push_beat(status_t st, logic signed [DATA_W-1:0] v, int idx,
                                    logic lst);
    list_beat_t b;
    b.status = st;
    b.value  = v;
    b.index  = POS_W'(idx);
    b.length = OLEN_W'(shadow_list.size());
    b.last   = lst;
    owed_beats.push_back(b);
  endfunction

  function automatic void apply_command(logic [2:0] req, logic [POS_W-1:0] pos,
                                        logic signed [DATA_W-1:0] v);
    status_t st;
    int      n;
    st = ST_OK;
    n  = shadow_list.size();
    case (req)
      REQ_INS_FRONT: st = insert_value(0, v);
      REQ_INS_END:   st = insert_value(n, v);
      REQ_INS_POS:   st = insert_value(pos, v);
      REQ_DEL_FRONT: st = delete_value(0);
      REQ_DEL_END:   st = (n == 0) ? ST_EMPTY : delete_value(n - 1);
      REQ_DEL_POS:   st = delete_value(pos);
      REQ_DISPLAY: begin
        if (n == 0) begin
          push_beat(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) push_beat(ST_OK, shadow_list[i], i, i == n - 1);
        end
        return;
      end
      default: st = ST_OK;
    endcase
    push_beat(st, '0, 0, 1'b1);
  endfunction

  always @(posedge clk) begin
    list_beat_t want;
    if (!rst_n) begin
      shadow_list.delete();
      owed_beats.delete();
    end else begin
      if (out_valid && !out_stall) begin
        checked++;
        if (owed_beats.size() == 0) begin
          errors++;
          $error("result beat with nothing owed: status %0d value %0d index %0d",
                 out_status, out_element_value, out_element_index);
        end else begin
          want = owed_beats.pop_front();
          if (out_status !== want.status) begin
            errors++;
            $error("status: expected %0d, got %0d", want.status, out_status);
          end
          if (out_element_value !== want.value) begin
            errors++;
            $error("element_value: expected %0d, got %0d", want.value, out_element_value);
          end
          if (out_element_index !== want.index) begin
            errors++;
            $error("element_index: expected %0d, got %0d", want.index, out_element_index);
          end
          if (out_length_out !== want.length) begin
            errors++;
            $error("length_out: expected %0d, got %0d", want.length, out_length_out);
          end
          if (out_last !== want.last) begin
            errors++;
            $error("last: expected %0d, got %0d", want.last, out_last);
          end
        end
      end
      if (in_valid && !in_stall) apply_command(in_req_type, in_position, in_value_in);
    end
    fail_count    <= errors;
    pending       <= owed_beats.size();
    list_len      <= shadow_list.size();
    beats_checked <= checked;
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the ordered list block.
// ----------------------------------------------------------------------------
// A short directed pass covers empty-list deletes and display, bad positions,
// value extremes and the unused request code. Random blocks then alternate
// between filling the list toward capacity, mixed traffic and draining it, with
// bursts of idle on both channels, one long output hold that backs the block
// up, and a full drain between blocks. The last blocks run with no idle.
// ----------------------------------------------------------------------------
module tb_top;
  import oli_pkg::*;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int MODE_FILL  = 0;
  localparam int MODE_MIXED = 1;
  localparam int MODE_DRAIN = 2;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 200;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [2:0]               in_req_type;
  logic [POS_W-1:0]         in_position;
  logic signed [DATA_W-1:0] in_value_in;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_element_value;
  logic [POS_W-1:0]         out_element_index;
  logic [OLEN_W-1:0]        out_length_out;
  logic                     out_last;

  int fail_count;
  int pending;
  int list_len;
  int beats_checked;
  int sent_count;
  int quiet_cycles;
  bit tx_idle_on;
  bit rx_idle_on;
  bit long_hold_go;

  ordered_list_insert_delete_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_position       (in_position),
    .in_value_in       (in_value_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_element_value (out_element_value),
    .out_element_index (out_element_index),
    .out_length_out    (out_length_out),
    .out_last          (out_last)
  );

  list_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_position       (in_position),
    .in_value_in       (in_value_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_element_value (out_element_value),
    .out_element_index (out_element_index),
    .out_length_out    (out_length_out),
    .out_last          (out_last),
    .fail_count        (fail_count),
    .pending           (pending),
    .list_len          (list_len),
    .beats_checked     (beats_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_cmd(input logic [2:0] req, input logic [POS_W-1:0] pos,
                          input logic signed [DATA_W-1:0] v);
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_position <= pos;
    in_value_in <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_cmd(input int mode);
    int                       r;
    int                       ins_pct;
    logic [2:0]               req;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] v;
    r       = $urandom_range(0, 99);
    ins_pct = (mode == MODE_FILL) ? 80 : (mode == MODE_DRAIN) ? 15 : 45;
    if (r < ins_pct) begin
      case ($urandom_range(0, 2))
        0:       req = REQ_INS_FRONT;
        1:       req = REQ_INS_END;
        default: req = REQ_INS_POS;
      endcase
    end else if (r < 92) begin
      case ($urandom_range(0, 2))
        0:       req = REQ_DEL_FRONT;
        1:       req = REQ_DEL_END;
        default: req = REQ_DEL_POS;
      endcase
    end else if (r < 98) begin
      req = REQ_DISPLAY;
    end else begin
      req = REQ_UNUSED;
    end
    if ($urandom_range(0, 9) < 7) begin
      pos = POS_W'($urandom_range(0, list_len));
    end else begin
      pos = POS_W'($urandom);
    end
    case ($urandom_range(0, 19))
      0:       v = 32'sh8000_0000;
      1:       v = 32'sh7fff_ffff;
      2:       v = '0;
      3:       v = -32'sd1;
      default: v = $urandom;
    endcase
    send_cmd(req, pos, v);
  endtask

  initial begin
    int mode;
    int n_items;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_DISPLAY;
    in_position <= '0;
    in_value_in <= '0;
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    long_hold_go = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_cmd(REQ_DISPLAY,   6'd0,  32'sd0);
    send_cmd(REQ_DEL_FRONT, 6'd0,  32'sd0);
    send_cmd(REQ_DEL_END,   6'd0,  32'sd0);
    send_cmd(REQ_DEL_POS,   6'd63, 32'sd0);
    send_cmd(REQ_INS_POS,   6'd1,  32'sd11);
    send_cmd(REQ_INS_POS,   6'd0,  32'sh8000_0000);
    send_cmd(REQ_INS_END,   6'd0,  32'sh7fff_ffff);
    send_cmd(REQ_INS_FRONT, 6'd0,  -32'sd1);
    send_cmd(REQ_INS_POS,   6'd3,  32'sd0);
    send_cmd(REQ_INS_POS,   6'd63, 32'sd5);
    send_cmd(REQ_UNUSED,    6'd63, 32'sh5a5a_a5a5);
    send_cmd(REQ_DISPLAY,   6'd0,  32'sd0);
    send_cmd(REQ_DEL_POS,   6'd4,  32'sd0);
    send_cmd(REQ_DEL_POS,   6'd63, 32'sd0);
    send_cmd(REQ_DEL_POS,   6'd1,  32'sd0);
    send_cmd(REQ_DEL_END,   6'd0,  32'sd0);
    send_cmd(REQ_DEL_FRONT, 6'd0,  32'sd0);
    send_cmd(REQ_DEL_FRONT, 6'd0,  32'sd0);
    send_cmd(REQ_DISPLAY,   6'd0,  32'sd0);
    wait_drained();

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int blk = 0; blk < 10; blk++) begin
      mode    = blk % 3;
      n_items = (mode == MODE_FILL) ? 60 : 38;
      if (blk == 4) begin
        tx_idle_on   = 1'b0;
        long_hold_go = 1'b1;
      end else if (blk == 5) begin
        tx_idle_on = 1'b1;
      end
      if (blk >= 8) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      for (int k = 0; k < n_items; k++) random_cmd(mode);
      wait_drained();
    end
    repeat (20) @(posedge clk);

    $display("tb: %0d commands driven and %0d result beats checked", sent_count,
             beats_checked);
    $display("tb: fill, mixed and drain phases with idle bursts and a long output hold");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
